FILE: hw/rtl/tfpb_pkg.sv
// shared constants, types and saturation helpers for the tilt filter pid balancer
`timescale 1ns / 1ps

package tfpb_pkg;

  // fixed point layout
  localparam int FRAC_BITS   = 24;
  localparam int DUTY_W      = 16;
  localparam int DUTY_SHIFT  = FRAC_BITS - DUTY_W;
  localparam int SMOOTH_FRAC = 16;
  localparam int GAIN_FRAC   = 8;

  // port and register widths
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int RAW_W       = 16;
  localparam int IN_TDATA_W  = 2 * RAW_W;
  localparam int OUT_TDATA_W = 24;

  // datapath widths
  localparam int NEG_W  = RAW_W + 1;
  localparam int X_W    = 32;
  localparam int ST_W   = 40;
  localparam int INT_W  = 48;
  localparam int OPA_W  = ST_W + 1;
  localparam int LO_W   = 24;
  localparam int MA_W   = LO_W + 1;
  localparam int MB_W   = CFG_W + 1;
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = 60;
  localparam int PID_W  = 51;
  localparam int MAG_W  = PID_W - 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_SCALE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_SCALE  = 3'd6;

  // register reset values
  localparam logic [CFG_W-1:0] RST_PROP_GAIN   = 16'd7680;
  localparam logic [CFG_W-1:0] RST_INTEG_GAIN  = 16'd26;
  localparam logic [CFG_W-1:0] RST_DERIV_GAIN  = 16'd17920;
  localparam logic [CFG_W-1:0] RST_SMOOTH      = 16'd62259;
  localparam logic [CFG_W-1:0] RST_DUTY_LIMIT  = 16'd49152;
  localparam logic [CFG_W-1:0] RST_ACCEL_SCALE = 16'd1024;
  localparam logic [CFG_W-1:0] RST_GYRO_SCALE  = 16'd36;

  // rounding offsets and saturation bounds
  localparam logic signed [ACC_W-1:0] RND_SMOOTH = ACC_W'(1) << (SMOOTH_FRAC - 1);
  localparam logic signed [ACC_W-1:0] RND_GAIN   = ACC_W'(1) << (GAIN_FRAC - 1);
  localparam logic signed [ACC_W-1:0] ST_MAX     = (ACC_W'(1) << (ST_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] ST_MIN     = ~ST_MAX;
  localparam logic signed [ACC_W-1:0] INT_MAX    = (ACC_W'(1) << (INT_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] INT_MIN    = ~INT_MAX;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_X,
    ST_S,
    ST_XC,
    ST_SC,
    ST_LP1,
    ST_HP0,
    ST_HP1,
    ST_HPW,
    ST_HPC,
    ST_ANG,
    ST_I0,
    ST_I1,
    ST_P0,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_PW,
    ST_PC,
    ST_MAG,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    OPA_NX,
    OPA_NG,
    OPA_D,
    OPA_E,
    OPA_ANG,
    OPA_DLT
  } a_src_e;

  typedef enum logic [1:0] {
    PART_LO,
    PART_HI,
    PART_FULL
  } part_e;

  typedef enum logic [2:0] {
    OPB_ACCEL,
    OPB_GYRO,
    OPB_SMOOTH,
    OPB_INTEG,
    OPB_PROP,
    OPB_DERIV
  } b_src_e;

  typedef enum logic [2:0] {
    ACC_ADD,
    ACC_ZERO,
    ACC_LP,
    ACC_RND_S,
    ACC_RND_G
  } acc_op_e;

  typedef struct packed {
    logic    vld;
    part_e   part;
    logic    load;
  } mac_req_t;

  typedef struct packed {
    logic    idle;
    logic    issue;
    a_src_e  a_src;
    part_e   part;
    b_src_e  b_src;
    acc_op_e acc_op;
    logic    cap_x;
    logic    cap_s;
    logic    cap_lp;
    logic    cap_hp;
    logic    cap_ang;
    logic    cap_int;
    logic    cap_prev;
    logic    cap_pid;
    logic    cap_mag;
    logic    load_out;
  } ctrl_t;

  function automatic logic signed [ST_W-1:0] sat_st(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    r = v;
    if (v > ST_MAX) begin
      r = ST_MAX;
    end else if (v < ST_MIN) begin
      r = ST_MIN;
    end
    return r[ST_W-1:0];
  endfunction

  function automatic logic signed [INT_W-1:0] sat_int(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    r = v;
    if (v > INT_MAX) begin
      r = INT_MAX;
    end else if (v < INT_MIN) begin
      r = INT_MIN;
    end
    return r[INT_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/tfpb_mac.sv
// shared multiply-accumulate unit: registered 25x17 product, then accumulate with shift
`timescale 1ns / 1ps

module tfpb_mac import tfpb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_req_t                req_i,
  input  logic signed [OPA_W-1:0] opa_i,
  input  logic        [CFG_W-1:0] opb_i,
  input  logic signed [ACC_W-1:0] init_i,
  output logic signed [ACC_W-1:0] acc_o
);

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic                     vld_q;
  logic                     hi_q;
  logic                     load_q;
  logic signed [ACC_W-1:0]  init_q;
  logic signed [ACC_W-1:0]  shifted;
  logic signed [ACC_W-1:0]  base;
  logic signed [ACC_W-1:0]  acc_d, acc_q;

  // wide operand is split into an unsigned low slice and a signed high slice
  always_comb begin
    case (req_i.part)
      PART_LO:   mul_a = $signed({1'b0, opa_i[LO_W-1:0]});
      PART_HI:   mul_a = MA_W'($signed(opa_i[OPA_W-1:LO_W]));
      default:   mul_a = $signed(opa_i[MA_W-1:0]);
    endcase
  end

  assign mul_b  = $signed({1'b0, opb_i});
  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= req_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    hi_q   <= (req_i.part == PART_HI);
    load_q <= req_i.load;
    init_q <= init_i;
    acc_q  <= acc_d;
  end

  always_comb begin
    shifted = hi_q ? (ACC_W'(prod_q) <<< LO_W) : ACC_W'(prod_q);
    base    = load_q ? init_q : acc_q;
    acc_d   = vld_q ? (base + shifted) : acc_q;
  end

  assign acc_o = acc_q;

endmodule

FILE: hw/rtl/tfpb_seq.sv
// sequencer: steps the shared multiplier through one sample's products
`timescale 1ns / 1ps

module tfpb_seq import tfpb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_fire_i,
  input  logic  out_free_i,
  output ctrl_t ctrl_o
);

  state_e state_d, state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire_i) state_d = ST_X;
      ST_X:    state_d = ST_S;
      ST_S:    state_d = ST_XC;
      ST_XC:   state_d = ST_SC;
      ST_SC:   state_d = ST_LP1;
      ST_LP1:  state_d = ST_HP0;
      ST_HP0:  state_d = ST_HP1;
      ST_HP1:  state_d = ST_HPW;
      ST_HPW:  state_d = ST_HPC;
      ST_HPC:  state_d = ST_ANG;
      ST_ANG:  state_d = ST_I0;
      ST_I0:   state_d = ST_I1;
      ST_I1:   state_d = ST_P0;
      ST_P0:   state_d = ST_P1;
      ST_P1:   state_d = ST_P2;
      ST_P2:   state_d = ST_P3;
      ST_P3:   state_d = ST_PW;
      ST_PW:   state_d = ST_PC;
      ST_PC:   state_d = ST_MAG;
      ST_MAG:  state_d = ST_OUT;
      ST_OUT:  if (out_free_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // each issued product passes through the product register, then into the accumulator register
  always_comb begin
    ctrl_o        = '0;
    ctrl_o.a_src  = OPA_NX;
    ctrl_o.part   = PART_LO;
    ctrl_o.b_src  = OPB_ACCEL;
    ctrl_o.acc_op = ACC_ADD;
    unique case (state_q)
      ST_IDLE: begin
        ctrl_o.idle = 1'b1;
      end
      ST_X: begin
        ctrl_o.issue  = 1'b1;
        ctrl_o.a_src  = OPA_NX;
        ctrl_o.part   = PART_FULL;
        ctrl_o.b_src  = OPB_ACCEL;
        ctrl_o.acc_op = ACC_ZERO;
      end
      ST_S: begin
        ctrl_o.issue  = 1'b1;
        ctrl_o.a_src  = OPA_NG;
        ctrl_o.part   = PART_FULL;
        ctrl_o.b_src  = OPB_GYRO;
        ctrl_o.acc_op = ACC_ZERO;
      end
      ST_XC: begin
        ctrl_o.cap_x = 1'b1;
      end
      ST_SC: begin
        ctrl_o.cap_s  = 1'b1;
        ctrl_o.issue  = 1'b1;
        ctrl_o.a_src  = OPA_D;
        ctrl_o.part   = PART_LO;
        ctrl_o.b_src  = OPB_SMOOTH;
        ctrl_o.acc_op = ACC_LP;
      end
      ST_LP1: begin
        ctrl_o.issue  = 1'b1;
        ctrl_o.a_src  = OPA_D;
        ctrl_o.part   = PART_HI;
        ctrl_o.b_src  = OPB_SMOOTH;
      end
      ST_HP0: begin
        ctrl_o.issue  = 1'b1;
        ctrl_o.a_src  = OPA_E;
        ctrl_o.part   = PART_LO;
        ctrl_o.b_src  = OPB_SMOOTH;
        ctrl_o.acc_op = ACC_RND_S;
      end
      ST_HP1: begin
        ctrl_o.cap_lp = 1'b1;
        ctrl_o.issue  = 1'b1;
        ctrl_o.a_src  = OPA_E;
        ctrl_o.part   = PART_HI;
        ctrl_o.b_src  = OPB_SMOOTH;
      end
      ST_HPW: begin
        ctrl_o.issue = 1'b0;
      end
      ST_HPC: begin
        ctrl_o.cap_hp = 1'b1;
      end
      ST_ANG: begin
        ctrl_o.cap_ang = 1'b1;
      end
      ST_I0: begin
        ctrl_o.issue  = 1'b1;
        ctrl_o.a_src  = OPA_ANG;
        ctrl_o.part   = PART_LO;
        ctrl_o.b_src  = OPB_INTEG;
        ctrl_o.acc_op = ACC_RND_G;
      end
      ST_I1: begin
        ctrl_o.issue  = 1'b1;
        ctrl_o.a_src  = OPA_ANG;
        ctrl_o.part   = PART_HI;
        ctrl_o.b_src  = OPB_INTEG;
      end
      ST_P0: begin
        ctrl_o.issue  = 1'b1;
        ctrl_o.a_src  = OPA_ANG;
        ctrl_o.part   = PART_LO;
        ctrl_o.b_src  = OPB_PROP;
        ctrl_o.acc_op = ACC_RND_G;
      end
      ST_P1: begin
        ctrl_o.cap_int = 1'b1;
        ctrl_o.issue   = 1'b1;
        ctrl_o.a_src   = OPA_ANG;
        ctrl_o.part    = PART_HI;
        ctrl_o.b_src   = OPB_PROP;
      end
      ST_P2: begin
        ctrl_o.issue  = 1'b1;
        ctrl_o.a_src  = OPA_DLT;
        ctrl_o.part   = PART_LO;
        ctrl_o.b_src  = OPB_DERIV;
      end
      ST_P3: begin
        ctrl_o.cap_prev = 1'b1;
        ctrl_o.issue    = 1'b1;
        ctrl_o.a_src    = OPA_DLT;
        ctrl_o.part     = PART_HI;
        ctrl_o.b_src    = OPB_DERIV;
      end
      ST_PW: begin
        ctrl_o.issue = 1'b0;
      end
      ST_PC: begin
        ctrl_o.cap_pid = 1'b1;
      end
      ST_MAG: begin
        ctrl_o.cap_mag = 1'b1;
      end
      ST_OUT: begin
        ctrl_o.load_out = out_free_i;
      end
      default: begin
        ctrl_o.idle = 1'b0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/tilt_filter_pid_balancer_unit.sv
// tilt estimator (complementary filter) with pid drive output, top level
// one sample is processed at a time: a new one is taken only when the sequencer is idle
// per sample, twelve passes go in turn through the one
//   shared 25x17 multiplier and its accumulator (five of the seven products split in halves)
// the next sample is taken while an earlier result still waits on the output
// reset: filter states, integral and previous angle clear, registers take their defaults
`timescale 1ns / 1ps

module tilt_filter_pid_balancer_unit import tfpb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input samples
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [15:0] accel_x, [31:16] gyro_y
  // results
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [15:0] duty, [16] forward, rest zero
  // register writes
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i
);

  ctrl_t    ctrl;
  mac_req_t mac_req;
  logic     in_fire;
  logic     out_free;

  logic [CFG_W-1:0] prop_gain_q, integ_gain_q, deriv_gain_q, smooth_q;
  logic [CFG_W-1:0] duty_limit_q, accel_scale_q, gyro_scale_q;

  logic signed [NEG_W-1:0] nx_d, nx_q, ng_d, ng_q;
  logic signed [X_W-1:0]   x_q, s_q;
  logic signed [ST_W-1:0]  lp_q, hp_q, angle_q, prev_q;
  logic signed [INT_W-1:0] integ_q;
  logic signed [PID_W-1:0] pid_d, pid_q;
  logic signed [PID_W-1:0] pid_neg;
  logic        [MAG_W-1:0] mag_d, mag_q;

  logic signed [OPA_W-1:0] opa;
  logic        [CFG_W-1:0] opb;
  logic signed [ACC_W-1:0] init;
  logic signed [ACC_W-1:0] acc;

  logic [DUTY_W-1:0] duty_d, duty_q;
  logic              fwd_q;
  logic              out_valid_q;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  tfpb_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q   <= RST_PROP_GAIN;
      integ_gain_q  <= RST_INTEG_GAIN;
      deriv_gain_q  <= RST_DERIV_GAIN;
      smooth_q      <= RST_SMOOTH;
      duty_limit_q  <= RST_DUTY_LIMIT;
      accel_scale_q <= RST_ACCEL_SCALE;
      gyro_scale_q  <= RST_GYRO_SCALE;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_PROP_GAIN:   prop_gain_q   <= cfg_wdata_i;
        CFG_INTEG_GAIN:  integ_gain_q  <= cfg_wdata_i;
        CFG_DERIV_GAIN:  deriv_gain_q  <= cfg_wdata_i;
        CFG_SMOOTH:      smooth_q      <= cfg_wdata_i;
        CFG_DUTY_LIMIT:  duty_limit_q  <= cfg_wdata_i;
        CFG_ACCEL_SCALE: accel_scale_q <= cfg_wdata_i;
        CFG_GYRO_SCALE:  gyro_scale_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // negated raw readings, 17 bits so that the most negative reading flips cleanly
  assign nx_d = -NEG_W'($signed(s_axis_tdata[RAW_W-1:0]));
  assign ng_d = -NEG_W'($signed(s_axis_tdata[IN_TDATA_W-1:RAW_W]));

  // operand selection for the shared unit
  always_comb begin
    case (ctrl.a_src)
      OPA_NX:  opa = OPA_W'(nx_q);
      OPA_NG:  opa = OPA_W'(ng_q);
      // low-pass rewritten as x*2^16 + (lp - x)*a
      OPA_D:   opa = OPA_W'(lp_q) - OPA_W'(x_q);
      OPA_E:   opa = OPA_W'(hp_q) + OPA_W'(s_q);
      OPA_ANG: opa = OPA_W'(angle_q);
      OPA_DLT: opa = OPA_W'(angle_q) - OPA_W'(prev_q);
      default: opa = OPA_W'(angle_q);
    endcase
  end

  always_comb begin
    case (ctrl.b_src)
      OPB_ACCEL:  opb = accel_scale_q;
      OPB_GYRO:   opb = gyro_scale_q;
      OPB_SMOOTH: opb = smooth_q;
      OPB_INTEG:  opb = integ_gain_q;
      OPB_PROP:   opb = prop_gain_q;
      OPB_DERIV:  opb = deriv_gain_q;
      default:    opb = smooth_q;
    endcase
  end

  always_comb begin
    case (ctrl.acc_op)
      ACC_LP:    init = (ACC_W'(x_q) <<< SMOOTH_FRAC) + RND_SMOOTH;
      ACC_RND_S: init = RND_SMOOTH;
      ACC_RND_G: init = RND_GAIN;
      default:   init = '0;
    endcase
  end

  assign mac_req.vld  = ctrl.issue;
  assign mac_req.part = ctrl.part;
  assign mac_req.load = (ctrl.acc_op != ACC_ADD);

  tfpb_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .opa_i  (opa),
    .opb_i  (opb),
    .init_i (init),
    .acc_o  (acc)
  );

  // kept state across samples
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q    <= '0;
      hp_q    <= '0;
      integ_q <= '0;
      prev_q  <= '0;
    end else begin
      if (ctrl.cap_lp) lp_q <= sat_st(acc >>> SMOOTH_FRAC);
      if (ctrl.cap_hp) hp_q <= sat_st(acc >>> SMOOTH_FRAC);
      if (ctrl.cap_int) integ_q <= sat_int(ACC_W'(integ_q) + (acc >>> GAIN_FRAC));
      if (ctrl.cap_prev) prev_q <= angle_q;
    end
  end

  assign pid_d   = PID_W'((acc >>> GAIN_FRAC) + ACC_W'(integ_q));
  assign pid_neg = -pid_q;
  assign mag_d   = pid_q[PID_W-1] ? pid_neg[MAG_W-1:0] : pid_q[MAG_W-1:0];

  always_comb begin
    if ((|mag_q[MAG_W-1:DUTY_SHIFT+DUTY_W])
        || (mag_q[DUTY_SHIFT+DUTY_W-1:DUTY_SHIFT] > duty_limit_q)) begin
      duty_d = duty_limit_q;
    end else begin
      duty_d = mag_q[DUTY_SHIFT+DUTY_W-1:DUTY_SHIFT];
    end
  end

  // per-sample working registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      nx_q <= nx_d;
      ng_q <= ng_d;
    end
    if (ctrl.cap_x) x_q <= acc[X_W-1:0];
    if (ctrl.cap_s) s_q <= acc[X_W-1:0];
    if (ctrl.cap_ang) angle_q <= sat_st(ACC_W'(lp_q) + ACC_W'(hp_q));
    if (ctrl.cap_pid) pid_q <= pid_d;
    if (ctrl.cap_mag) mag_q <= mag_d;
    if (ctrl.load_out) begin
      duty_q <= duty_d;
      fwd_q  <= !angle_q[ST_W-1] && (angle_q != '0);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign s_axis_tready = ctrl.idle;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - DUTY_W - 1)'(0), fwd_q, duty_q};

endmodule

FILE: tb/tb_tilt_filter_pid_balancer_unit.sv
// self-checking testbench for the tilt filter pid balancer: random imu samples, register sweeps
`timescale 1ns / 1ps

module tb_tilt_filter_pid_balancer_unit;
  import tfpb_pkg::*;

  localparam int NUM_REGS     = 7;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int RUN_LIMIT_NS = 3_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic              fwd;
    logic [DUTY_W-1:0] duty;
  } drive_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [15:0] accel_x, [31:16] gyro_y
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [15:0] duty, [16] forward
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr_i = '0;
  logic [CFG_W-1:0]       cfg_wdata_i = '0;

  // predictor copy of the registers and the filter / pid state
  logic [CFG_W-1:0] cfg_shadow [0:NUM_REGS-1];
  longint lp_angle = 0;
  longint hp_angle = 0;
  longint integ_acc = 0;
  longint last_angle = 0;

  logic [IN_TDATA_W-1:0] sample_q [$];
  drive_t                drive_pending_q [$];

  logic tx_burst = 1'b0;
  logic rx_burst = 1'b0;
  logic hold_tgl = 1'b0;
  logic hold_seen = 1'b0;
  int   tx_wait = 0;
  int   rx_stall = 0;
  int   hold_left = 0;

  int mismatches = 0;
  int samples_taken = 0;
  int drives_checked = 0;
  int settings_used = 1;

  tilt_filter_pid_balancer_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // floor((v + half) / 2^n)
  function automatic longint round_shift(input longint v, input int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clamp_bits(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      return hi;
    end
    if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  function automatic drive_t predict_drive(input logic signed [RAW_W-1:0] ax,
                                           input logic signed [RAW_W-1:0] gy);
    longint coef;
    longint tilt_x;
    longint tilt_s;
    longint angle;
    longint pid;
    longint mag;
    drive_t r;
    coef   = longint'(cfg_shadow[CFG_SMOOTH]);
    tilt_x = -longint'(ax) * longint'(cfg_shadow[CFG_ACCEL_SCALE]);
    tilt_s = -longint'(gy) * longint'(cfg_shadow[CFG_GYRO_SCALE]);
    lp_angle = clamp_bits(round_shift(lp_angle * coef
                 + tilt_x * ((longint'(1) << SMOOTH_FRAC) - coef), SMOOTH_FRAC), ST_W);
    hp_angle = clamp_bits(round_shift((hp_angle + tilt_s) * coef, SMOOTH_FRAC), ST_W);
    angle = clamp_bits(lp_angle + hp_angle, ST_W);
    integ_acc = clamp_bits(integ_acc + round_shift(angle
                  * longint'(cfg_shadow[CFG_INTEG_GAIN]), GAIN_FRAC), INT_W);
    pid = round_shift(angle * longint'(cfg_shadow[CFG_PROP_GAIN])
            + (angle - last_angle) * longint'(cfg_shadow[CFG_DERIV_GAIN]), GAIN_FRAC)
          + integ_acc;
    last_angle = angle;
    mag = (pid < 0) ? -pid : pid;
    mag = mag >>> (FRAC_BITS - DUTY_W);
    if (mag > longint'(cfg_shadow[CFG_DUTY_LIMIT])) begin
      mag = longint'(cfg_shadow[CFG_DUTY_LIMIT]);
    end
    r.duty = mag[DUTY_W-1:0];
    r.fwd  = (angle > 0);
    return r;
  endfunction

  // sample source: a random wait, or none in burst mode, is drawn for each sample
  always @(posedge clk_i or negedge rst_ni) begin : sample_drv
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_wait <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (tx_wait != 0) begin
        tx_wait <= tx_wait - 1;
        s_axis_tvalid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        s_axis_tdata <= sample_q.pop_front();
        s_axis_tvalid <= 1'b1;
        tx_wait <= tx_burst ? 0 : $urandom_range(0, 9);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink: random stall after each result, long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin : drive_sink
    int st;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_stall <= 0;
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else begin
      st = rx_stall;
      if (m_axis_tvalid && m_axis_tready) begin
        st = rx_burst ? 0 : $urandom_range(0, 9);
      end
      if (hold_tgl != hold_seen) begin
        hold_seen <= hold_tgl;
        hold_left <= HOLD_CYCLES;
        rx_stall <= st;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rx_stall <= st;
        m_axis_tready <= 1'b0;
      end else if (st != 0) begin
        rx_stall <= st - 1;
        m_axis_tready <= 1'b0;
      end else begin
        rx_stall <= 0;
        m_axis_tready <= 1'b1;
      end
    end
  end

  // check results first so a stray result is not masked by a sample taken the same edge
  always @(posedge clk_i) begin : drive_check
    drive_t want;
    drive_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.duty = m_axis_tdata[DUTY_W-1:0];
        got.fwd  = m_axis_tdata[DUTY_W];
        drives_checked++;
        if (drive_pending_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual duty %0d forward %0b",
                   $time, got.duty, got.fwd);
          mismatches++;
        end else begin
          want = drive_pending_q.pop_front();
          if (got.duty !== want.duty) begin
            $display("%0t: duty mismatch: expected %0d, actual %0d",
                     $time, want.duty, got.duty);
            mismatches++;
          end
          if (got.fwd !== want.fwd) begin
            $display("%0t: forward mismatch: expected %0b, actual %0b",
                     $time, want.fwd, got.fwd);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        drive_pending_q.push_back(predict_drive(s_axis_tdata[RAW_W-1:0],
                                                s_axis_tdata[IN_TDATA_W-1:RAW_W]));
        samples_taken++;
      end
    end
  end

  task automatic queue_sample(input logic [RAW_W-1:0] ax, input logic [RAW_W-1:0] gy);
    sample_q.push_back({gy, ax});
  endtask

  // raw reading with extra weight on the rails, zero and minus one
  function automatic logic [RAW_W-1:0] raw_reading();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  task automatic queue_random(input int n);
    repeat (n) queue_sample(raw_reading(), raw_reading());
  endtask

  // wait until every sample is taken and every result has come back
  task automatic settle_block();
    do @(posedge clk_i);
    while (sample_q.size() != 0 || s_axis_tvalid || drive_pending_q.size() != 0);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    if (idx <= CFG_GYRO_SCALE) begin
      cfg_shadow[idx] = val;
    end
  endtask

  task automatic load_settings(input logic [CFG_W-1:0] prop, input logic [CFG_W-1:0] integ,
                               input logic [CFG_W-1:0] deriv, input logic [CFG_W-1:0] smooth,
                               input logic [CFG_W-1:0] limit, input logic [CFG_W-1:0] ascale,
                               input logic [CFG_W-1:0] gscale);
    // an unmapped index must leave every register alone
    write_reg(CFG_UNUSED, CFG_W'($urandom));
    write_reg(CFG_PROP_GAIN, prop);
    write_reg(CFG_INTEG_GAIN, integ);
    write_reg(CFG_DERIV_GAIN, deriv);
    write_reg(CFG_SMOOTH, smooth);
    write_reg(CFG_DUTY_LIMIT, limit);
    write_reg(CFG_ACCEL_SCALE, ascale);
    write_reg(CFG_GYRO_SCALE, gscale);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    settings_used++;
  endtask

  task automatic load_random_settings();
    load_settings(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                  CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
  endtask

  initial begin : stimulus
    cfg_shadow[CFG_PROP_GAIN]   = RST_PROP_GAIN;
    cfg_shadow[CFG_INTEG_GAIN]  = RST_INTEG_GAIN;
    cfg_shadow[CFG_DERIV_GAIN]  = RST_DERIV_GAIN;
    cfg_shadow[CFG_SMOOTH]      = RST_SMOOTH;
    cfg_shadow[CFG_DUTY_LIMIT]  = RST_DUTY_LIMIT;
    cfg_shadow[CFG_ACCEL_SCALE] = RST_ACCEL_SCALE;
    cfg_shadow[CFG_GYRO_SCALE]  = RST_GYRO_SCALE;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: zero angle from reset, rails of both readings, plus and minus one, alternating bit patterns
    queue_sample(16'h0000, 16'h0000);
    queue_sample(16'h0000, 16'h0000);
    queue_sample(16'h8000, 16'h0000);
    queue_sample(16'h7FFF, 16'h0000);
    queue_sample(16'h0000, 16'h8000);
    queue_sample(16'h0000, 16'h7FFF);
    queue_sample(16'h8000, 16'h8000);
    queue_sample(16'h7FFF, 16'h7FFF);
    queue_sample(16'h8000, 16'h7FFF);
    queue_sample(16'h7FFF, 16'h8000);
    queue_sample(16'h0001, 16'hFFFF);
    queue_sample(16'hFFFF, 16'h0001);
    queue_sample(16'h5555, 16'hAAAA);
    queue_sample(16'hAAAA, 16'h5555);
    queue_sample(16'h0000, 16'h0000);
    settle_block();

    // random gains, with the sink holding off long enough to back up the input
    load_random_settings();
    hold_tgl <= ~hold_tgl;
    queue_random(120);
    settle_block();

    // every register at zero: angle stays zero, duty limited to zero
    load_settings('0, '0, '0, '0, '0, '0, '0);
    queue_random(40);
    settle_block();

    // every register at its top: a pinned gyro drives the high-pass filter and integral into saturation
    load_settings('1, '1, '1, '1, '1, '1, '1);
    repeat (260) queue_sample(raw_reading(), 16'h8000);
    queue_random(20);
    settle_block();

    // back-to-back traffic on both sides
    load_random_settings();
    tx_burst <= 1'b1;
    rx_burst <= 1'b1;
    queue_random(75);
    settle_block();

    tx_burst <= 1'b0;
    rx_burst <= 1'b0;
    load_settings(RST_PROP_GAIN, RST_INTEG_GAIN, RST_DERIV_GAIN, RST_SMOOTH,
                  RST_DUTY_LIMIT, RST_ACCEL_SCALE, RST_GYRO_SCALE);
    queue_random(75);
    settle_block();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d imu samples sent, %0d drive results checked under %0d register settings",
             samples_taken, drives_checked, settings_used);
    $display("settings covered defaults, all-zero, all-max with saturation, and random gains");
    if (mismatches == 0 && drive_pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule
